### rtl/core/smv_pkg.sv
// Shared constants, types and helpers for the sparse matrix-vector multiplier.
package smv_pkg;

    // Dimension of the dense vector and the field widths of an item.
    localparam int MAX_DIM = 4096;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 12;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;

    // Entries reachable by a column index; the store never needs more than that.
    localparam int VS_DEPTH = (MAX_DIM < (1 << COL_W)) ? MAX_DIM : (1 << COL_W);
    localparam int VS_AW    = (VS_DEPTH > 1) ? $clog2(VS_DEPTH) : 1;

    // Full product width and the width kept after dropping the fraction bits.
    localparam int FULL_W = 2 * DATA_W;
    localparam int PROD_W = FULL_W - FRAC_W;
    localparam int ACC_W  = PROD_W + 1;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = FIFO_AW + 1;

    // Request type codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ENTRY = 1'b1;

    // A matrix entry on its way to the multiplier.
    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] value;
        logic                     fin;
        logic                     in_range;
    } t_entry;

    // One queue entry: an optional finished row (row rise) and an optional final row.
    typedef struct packed {
        logic                     has_a;
        logic [ROW_W-1:0]         row_a;
        logic signed [DATA_W-1:0] sum_a;
        logic                     has_b;
        logic [ROW_W-1:0]         row_b;
        logic signed [DATA_W-1:0] sum_b;
    } t_res;

    // True when a column index addresses an entry of the vector store.
    function automatic logic col_in_range(input logic [COL_W-1:0] col);
        return ({{(32 - COL_W){1'b0}}, col} < 32'(VS_DEPTH));
    endfunction

endpackage

### rtl/core/smv_vec_mem.sv
// Dense vector store: one write port for loads, one registered read port for entries.
module smv_vec_mem (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [smv_pkg::VS_AW-1:0]        i_wr_addr,
    input  logic [smv_pkg::DATA_W-1:0]       i_wr_data,
    input  logic                             i_rd_en,
    input  logic [smv_pkg::VS_AW-1:0]        i_rd_addr,
    output logic [smv_pkg::DATA_W-1:0]       o_rd_data
);

    logic [smv_pkg::DATA_W-1:0] r_mem [smv_pkg::VS_DEPTH];
    logic [smv_pkg::DATA_W-1:0] r_rd_data;

    // Loads write the element; entries read theirs through the registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/smv_mac.sv
// Multiply stage and row accumulator with saturation and row-change detection.
module smv_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  smv_pkg::t_entry                  i_entry,
    input  logic [smv_pkg::DATA_W-1:0]       i_elem,
    output logic                             o_push,
    output smv_pkg::t_res                    o_res,
    output logic [1:0]                       o_inflight
);

    logic                              r_v1;
    smv_pkg::t_entry                   r_s1;
    logic                              r_v2;
    logic [smv_pkg::ROW_W-1:0]         r_row2;
    logic                              r_fin2;
    logic signed [smv_pkg::PROD_W-1:0] r_prod;
    logic [smv_pkg::ROW_W-1:0]         r_cur_row;
    logic signed [smv_pkg::DATA_W-1:0] r_sum;

    logic signed [smv_pkg::FULL_W-1:0] w_full;
    logic                              w_rise;
    logic signed [smv_pkg::DATA_W-1:0] w_base;
    logic signed [smv_pkg::ACC_W-1:0]  w_acc;
    logic signed [smv_pkg::DATA_W-1:0] w_sat;
    logic [smv_pkg::ROW_W-1:0]         w_row;

    // Exact signed product; a column outside the store contributes zero.
    assign w_full = r_s1.in_range ? ($signed(i_elem) * $signed(r_s1.value))
                                  : $signed({smv_pkg::FULL_W{1'b0}});

    // A higher row closes the current one and starts from zero.
    assign w_rise = r_v2 && (r_row2 > r_cur_row);
    assign w_base = w_rise ? '0 : r_sum;
    assign w_row  = w_rise ? r_row2 : r_cur_row;
    assign w_acc  = {{(smv_pkg::ACC_W - smv_pkg::DATA_W){w_base[smv_pkg::DATA_W-1]}}, w_base}
                  + {r_prod[smv_pkg::PROD_W-1], r_prod};

    // Saturate when the upper bits are not a pure sign extension.
    always_comb begin
        if (&w_acc[smv_pkg::ACC_W-1:smv_pkg::DATA_W-1]
                || ~|w_acc[smv_pkg::ACC_W-1:smv_pkg::DATA_W-1]) begin
            w_sat = w_acc[smv_pkg::DATA_W-1:0];
        end else if (w_acc[smv_pkg::ACC_W-1]) begin
            w_sat = {1'b1, {(smv_pkg::DATA_W - 1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(smv_pkg::DATA_W - 1){1'b1}}};
        end
    end

    // Result entry: the closed row first, then the final row.
    assign o_push       = r_v2 && (w_rise || r_fin2);
    assign o_res.has_a  = w_rise;
    assign o_res.row_a  = r_cur_row;
    assign o_res.sum_a  = r_sum;
    assign o_res.has_b  = r_fin2;
    assign o_res.row_b  = w_row;
    assign o_res.sum_b  = w_sat;
    assign o_inflight   = {1'b0, r_v1} + {1'b0, r_v2};

    // Control and accumulator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_cur_row <= '0;
            r_sum     <= '0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            if (r_v2) begin
                if (r_fin2) begin
                    r_cur_row <= '0;
                    r_sum     <= '0;
                end else begin
                    r_cur_row <= w_row;
                    r_sum     <= w_sat;
                end
            end
        end
    end

    // Payload pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_entry;
        end
        r_row2 <= r_s1.row;
        r_fin2 <= r_s1.fin;
        r_prod <= w_full[smv_pkg::FULL_W-1:smv_pkg::FRAC_W];
    end

    // The final entry leaves the accumulator cleared.
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_fin2) |=> (r_cur_row == '0 && r_sum == '0))
        else $error("accumulator not cleared after final entry");

    // A closed row is always a lower row than the one that replaces it.
    a_rise_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.has_a && o_res.has_b) |-> (o_res.row_a < o_res.row_b))
        else $error("row rise out of order");

endmodule

### rtl/core/smv_res_fifo.sv
// Result queue that splits each entry into one or two output items.
module smv_res_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  smv_pkg::t_res                    i_res,
    output logic [smv_pkg::LVL_W-1:0]        o_level,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [smv_pkg::ROW_W-1:0]        o_out_row,
    output logic signed [smv_pkg::DATA_W-1:0] o_row_sum,
    output logic                             o_done_res
);

    smv_pkg::t_res               r_mem [smv_pkg::FIFO_DEPTH];
    logic [smv_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [smv_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [smv_pkg::LVL_W-1:0]   r_count;
    logic                        r_half;

    smv_pkg::t_res               w_head;
    logic                        w_show_a;
    logic                        w_take;
    logic                        w_pop;

    // Head entry: the closed row goes out first, unless it was already taken.
    assign w_head     = r_mem[r_rd_ptr];
    assign w_show_a   = w_head.has_a && !r_half;
    assign o_valid    = (r_count != '0);
    assign o_out_row  = w_show_a ? w_head.row_a : w_head.row_b;
    assign o_row_sum  = w_show_a ? w_head.sum_a : w_head.sum_b;
    assign o_done_res = !w_show_a;
    assign o_level    = r_count;

    assign w_take = o_valid && !i_stall;
    assign w_pop  = w_take && !(w_show_a && w_head.has_b);

    // Pointers, fill level and the half-taken flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_half   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
            if (w_take) begin
                r_half <= w_show_a && w_head.has_b;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    // The input credit check keeps room for every entry in flight.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < smv_pkg::LVL_W'(smv_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    // Half-taken only on a valid two-row entry.
    a_half_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (o_valid && w_head.has_a && w_head.has_b))
        else $error("half-taken flag on a single-row entry");

endmodule

### rtl/core/sparse_matrix_vector_multiply_top.sv
// Top level of the streaming sparse matrix times dense vector multiplier.
// The block takes one item per cycle while it does not stall its input. A vector
// load writes its element into the 4096-entry store at the edge it is accepted; a
// matrix entry reads the store, is multiplied in the next cycle and reaches the row
// accumulator in the cycle after that, at whose end its results are written into
// the output queue. Results leave an eight-entry queue at one per cycle while the
// output is not stalled; an entry that both raises the row and ends the product
// gives two results, which leave one after the other. Input is stalled while the
// queue level plus the entries still in the multiply path reach the queue depth.
// The vector store needs no clearing after reset.
module sparse_matrix_vector_multiply_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic [smv_pkg::ROW_W-1:0]         i_row_index,
    input  logic [smv_pkg::COL_W-1:0]         i_col_index,
    input  logic signed [smv_pkg::DATA_W-1:0] i_value,
    input  logic                              i_final_entry,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [smv_pkg::ROW_W-1:0]         o_out_row,
    output logic signed [smv_pkg::DATA_W-1:0] o_row_sum,
    output logic                              o_done_res
);

    logic                          w_accept;
    logic                          w_in_range;
    logic                          w_load;
    logic                          w_entry_acc;
    logic [smv_pkg::VS_AW-1:0]     w_addr;
    logic [smv_pkg::DATA_W-1:0]    w_elem;
    smv_pkg::t_entry               w_entry;
    logic                          w_push;
    smv_pkg::t_res                 w_res;
    logic [1:0]                    w_inflight;
    logic [smv_pkg::LVL_W-1:0]     w_level;

    // Credit check: every entry in the multiply path may need one queue slot.
    assign o_stall = ({1'b0, w_level} + {{(smv_pkg::LVL_W - 1){1'b0}}, w_inflight})
                     >= (smv_pkg::LVL_W + 1)'(smv_pkg::FIFO_DEPTH);

    // Decode the accepted item.
    assign w_accept    = i_valid && !o_stall;
    assign w_in_range  = smv_pkg::col_in_range(i_col_index);
    assign w_addr      = i_col_index[smv_pkg::VS_AW-1:0];
    assign w_load      = w_accept && (i_req_type == smv_pkg::REQ_LOAD) && w_in_range;
    assign w_entry_acc = w_accept && (i_req_type == smv_pkg::REQ_ENTRY);

    assign w_entry.row      = i_row_index;
    assign w_entry.value    = i_value;
    assign w_entry.fin      = i_final_entry;
    assign w_entry.in_range = w_in_range;

    smv_vec_mem u_vec_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (w_addr),
        .i_wr_data (i_value),
        .i_rd_en   (w_entry_acc),
        .i_rd_addr (w_addr),
        .o_rd_data (w_elem)
    );

    smv_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_entry_acc),
        .i_entry    (w_entry),
        .i_elem     (w_elem),
        .o_push     (w_push),
        .o_res      (w_res),
        .o_inflight (w_inflight)
    );

    smv_res_fifo u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_res      (w_res),
        .o_level    (w_level),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_row  (o_out_row),
        .o_row_sum  (o_row_sum),
        .o_done_res (o_done_res)
    );

endmodule
